/* design/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants for the sobel gradient magnitude unit
// register indexes, field widths and the front to back transfer record
// ----------------------------------------------------------------------------
package sgm_pkg;

	localparam int unsigned MaxWidthDefault = 1024;
	localparam int unsigned QDepth = 8;
	localparam int unsigned PixW   = 8;
	localparam int unsigned GradW  = 11;
	localparam int unsigned MagW   = 15;
	localparam int unsigned RowW   = 16;
	localparam int unsigned ColOutW = 10;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned SqW    = 21;   // h*h+v*v <= 2*1020^2
	localparam int unsigned RadW   = 30;   // 256*(h*h+v*v) fits in 30 bits
	localparam logic [10:0] WidthReset  = 11'd512;
	localparam logic [15:0] HeightReset = 16'd512;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_DONE
	} sq_state_t;

	// window sums handed from front to back
	typedef struct packed {
		logic signed [GradW-1:0] gh;
		logic signed [GradW-1:0] gv;
		logic [RowW-1:0]         row;
		logic [ColOutW-1:0]      col;
		logic                    last;
	} grad_rec_t;

endpackage

/* design/sgm_front.sv */
// ----------------------------------------------------------------------------
// sgm_front: line stores, 3x3 window and sobel sums
// takes one pixel per transfer and emits one record per interior pixel
// ----------------------------------------------------------------------------
module sgm_front import sgm_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  logic [10:0]     image_width,
	input  logic [15:0]     image_height,
	input  logic            in_valid,
	input  logic [PixW-1:0] pixel,
	output logic            rec_valid,
	output grad_rec_t       rec
);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

	logic [PixW-1:0] store_a [MAX_WIDTH];
	logic [PixW-1:0] store_b [MAX_WIDTH];
	logic [PixW-1:0] win_q [6];
	logic [CW-1:0]   col_q;
	logic [RowW-1:0] row_q;
	logic [CW-1:0]   w_eff;
	logic [RowW-1:0] h_eff;
	logic [AW-1:0]   idx;
	logic [PixW-1:0] top, mid, bot;
	logic            col_end;

	// stage 1 registers: captured pixel and position
	logic            v_s1;
	logic [PixW-1:0] bot_s1;
	logic [AW-1:0]   idx_s1;
	logic [CW-1:0]   col_s1;
	logic [RowW-1:0] row_s1;
	logic            last_s1;
	logic [PixW-1:0] rd_a_s1, rd_b_s1;

	always_comb begin
		if (image_width < 11'd3)
			w_eff = CW'(3);
		else if ({21'd0, image_width} > 32'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(image_width);
		h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
	end

	assign idx     = col_q[AW-1:0];
	assign col_end = (col_q == w_eff - CW'(1));

	// position counters and memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			if (in_valid) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= (row_q == h_eff - 16'd1) ? '0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			bot_s1  <= pixel;
			idx_s1  <= idx;
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= col_end && (row_q == h_eff - 16'd1);
			rd_a_s1 <= store_a[idx];
			rd_b_s1 <= store_b[idx];
		end
	end

	// a stage 1 write to the same entry is impossible: width >= 3
	assign top = rd_b_s1;
	assign mid = rd_a_s1;
	assign bot = bot_s1;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			store_b[idx_s1] <= mid;
			store_a[idx_s1] <= bot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (restart) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	logic signed [GradW-1:0] l0, l1, l2, m0, m2, tt, mm, bb;
	always_comb begin
		l0 = GradW'({1'b0, win_q[0]});
		l1 = GradW'({1'b0, win_q[1]});
		l2 = GradW'({1'b0, win_q[2]});
		m0 = GradW'({1'b0, win_q[3]});
		m2 = GradW'({1'b0, win_q[5]});
		tt = GradW'({1'b0, top});
		mm = GradW'({1'b0, mid});
		bb = GradW'({1'b0, bot});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rec_valid <= 1'b0;
		else
			rec_valid <= v_s1 && !restart && row_s1 >= 16'd2 && col_s1 >= CW'(2);
	end

	always_ff @(posedge clk) begin
		rec.gh   <= (l0 + (l1 <<< 1) + l2) - (tt + (mm <<< 1) + bb);
		rec.gv   <= (l0 + (m0 <<< 1) + tt) - (l2 + (m2 <<< 1) + bb);
		rec.row  <= row_s1 - 16'd1;
		rec.col  <= ColOutW'(col_s1 - CW'(1));
		rec.last <= last_s1;
	end

endmodule

/* design/sgm_fifo.sv */
// ----------------------------------------------------------------------------
// sgm_fifo: small queue of gradient records between front and back
// ----------------------------------------------------------------------------
module sgm_fifo import sgm_pkg::*; #(
	parameter int unsigned DEPTH = QDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  grad_rec_t wdata,
	input  logic      rd,
	output grad_rec_t rdata,
	output logic      nonempty,
	output logic      almost_full
);
	localparam int unsigned AW = $clog2(DEPTH);
	grad_rec_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	assign rdata       = mem_q[rp_q];
	assign nonempty    = (cnt_q != '0);
	// three records may still be in the front pipeline
	assign almost_full = (cnt_q >= (AW+1)'(DEPTH-3));

endmodule

/* design/sgm_back.sv */
// ----------------------------------------------------------------------------
// sgm_back: magnitude by a digit-serial integer square root
// one result bit per cycle, output register toward the consumer
// ----------------------------------------------------------------------------
module sgm_back import sgm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rec_avail,
	input  grad_rec_t            rec,
	output logic                 rec_take,
	input  logic                 pop,
	output logic                 empty,
	output logic signed [GradW-1:0] grad_horizontal,
	output logic signed [GradW-1:0] grad_vertical,
	output logic [MagW-1:0]      magnitude,
	output logic [RowW-1:0]      center_row,
	output logic [ColOutW-1:0]   center_col,
	output logic                 last_of_frame
);
	sq_state_t st_q, st_d;
	grad_rec_t rec_q;
	logic [MagW-1:0]   root_q;
	logic [3:0]        step_q;
	logic              out_full_q;
	logic signed [2*GradW-1:0] hh, vv;
	logic [SqW-1:0]    sq;
	logic              fire;

	assign hh = rec.gh * rec.gh;
	assign vv = rec.gv * rec.gv;
	assign sq = SqW'(hh) + SqW'(vv);

	assign fire = (st_q == SQ_DONE) && (!out_full_q || pop);

	always_comb begin
		unique case (st_q)
			SQ_IDLE: st_d = rec_avail ? SQ_RUN : SQ_IDLE;
			SQ_RUN:  st_d = (step_q == 4'd0) ? SQ_DONE : SQ_RUN;
			SQ_DONE: st_d = fire ? SQ_IDLE : SQ_DONE;
			default: st_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		rec_take = (st_q == SQ_IDLE) && rec_avail;
	end

	// rad holds the unconsumed radicand bits, part the partial remainder
	logic [RadW-1:0]  rad_q;
	logic [MagW+2:0]  part_q;
	logic [MagW+2:0]  pnext;
	logic [MagW+2:0]  tsub;
	always_comb begin
		pnext = {part_q[MagW:0], rad_q[RadW-1 -: 2]};
		tsub  = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= SQ_IDLE;
			out_full_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (fire) out_full_q <= 1'b1;
			else if (pop) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			rec_q  <= rec;
			rad_q  <= {1'b0, sq, 8'd0};
			part_q <= '0;
			root_q <= '0;
			step_q <= 4'd14;
		end else if (st_q == SQ_RUN) begin
			rad_q  <= rad_q << 2;
			step_q <= step_q - 4'd1;
			if (pnext >= tsub) begin
				part_q <= pnext - tsub;
				root_q <= {root_q[MagW-2:0], 1'b1};
			end else begin
				part_q <= pnext;
				root_q <= {root_q[MagW-2:0], 1'b0};
			end
		end
		if (fire) begin
			grad_horizontal <= rec_q.gh;
			grad_vertical   <= rec_q.gv;
			magnitude       <= root_q;
			center_row      <= rec_q.row;
			center_col      <= rec_q.col;
			last_of_frame   <= rec_q.last;
		end
	end

	assign empty = !out_full_q;

endmodule

/* design/sobel_gradient_magnitude_unit.sv */
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_unit: streaming 3x3 sobel gradient and magnitude
// path: the pixel that completes a window passes stage 1, the record
// register, the queue, the square root and its output register to the ports
// throughput: the front takes a pixel a cycle while full is low; the square
// root takes a record only when idle; full holds input once the queue fills
// reset clears counters, window and queues; line stores keep old data
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit import sgm_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [PixW-1:0]         pixel,
	input  logic                    pop,
	output logic                    empty,
	output logic signed [GradW-1:0] grad_horizontal,
	output logic signed [GradW-1:0] grad_vertical,
	output logic [MagW-1:0]         magnitude,
	output logic [RowW-1:0]         center_row,
	output logic [ColOutW-1:0]      center_col,
	output logic                    last_of_frame,
	input  logic                    cfg_we,
	input  logic [CfgIdxW-1:0]      cfg_index,
	input  logic [CfgW-1:0]         cfg_data
);
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic        restart;
	logic        in_xfer;
	logic        rec_valid, rec_take, q_nonempty, q_afull;
	grad_rec_t   rec, q_rec;

	// config writes restart the frame
	assign restart = cfg_we;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall input while the queue could overflow
	assign full    = q_afull;
	assign in_xfer = push && !full;

	sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .restart,
		.image_width(width_q), .image_height(height_q),
		.in_valid(in_xfer), .pixel,
		.rec_valid, .rec
	);

	sgm_fifo #(.DEPTH(QDepth)) u_fifo (
		.clk, .arst_n,
		.wr(rec_valid), .wdata(rec),
		.rd(rec_take), .rdata(q_rec),
		.nonempty(q_nonempty), .almost_full(q_afull)
	);

	sgm_back u_back (
		.clk, .arst_n,
		.rec_avail(q_nonempty), .rec(q_rec), .rec_take,
		.pop, .empty,
		.grad_horizontal, .grad_vertical, .magnitude,
		.center_row, .center_col, .last_of_frame
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_afull |-> !in_xfer) else $error("pixel transfer while queue near full");
	a_take_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		rec_take |-> q_nonempty) else $error("square root took from empty queue");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sobel_gradient_magnitude_unit
// a few hand-checked frames, then random frames of many sizes, each
// transfer checked against an in-bench model of the window and sqrt
// ----------------------------------------------------------------------------
module tb;
	import sgm_pkg::*;

	// one result record as it leaves the block
	typedef struct {
		logic [GradW-1:0]   gh;
		logic [GradW-1:0]   gv;
		logic [MagW-1:0]    mag;
		logic [RowW-1:0]    row;
		logic [ColOutW-1:0] col;
		logic               last;
	} grad_res_t;

	// directed row: a register write or a pixel, optionally with a typed result
	typedef struct {
		bit             is_cfg;
		reg_idx_t       idx;
		logic [CfgW-1:0] data;
		logic [PixW-1:0] pix;
		bit             typed;
		grad_res_t      res;
	} dir_row_t;

	localparam int unsigned MaxW = 1024;
	localparam int unsigned DrainCycles = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [PixW-1:0] pixel = '0;
	logic pop = 1'b0;
	logic empty;
	logic signed [GradW-1:0] grad_horizontal, grad_vertical;
	logic [MagW-1:0] magnitude;
	logic [RowW-1:0] center_row;
	logic [ColOutW-1:0] center_col;
	logic last_of_frame;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;

	// in-bench copy of the block state
	logic [7:0]  row_above [MaxW];
	logic [7:0]  row_two_above [MaxW];
	logic [7:0]  win [6];
	int unsigned next_col, next_row;
	logic [10:0] width_reg;
	logic [15:0] height_reg;

	grad_res_t pending_grads [$];
	int unsigned err_count = 0;
	int unsigned send_idle_pct = 31;
	int unsigned recv_idle_pct = 86;
	bit hold_off_req = 1'b0;

	always #5 clk = ~clk;

	sobel_gradient_magnitude_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.pop(pop), .empty(empty), .grad_horizontal(grad_horizontal),
		.grad_vertical(grad_vertical), .magnitude(magnitude),
		.center_row(center_row), .center_col(center_col),
		.last_of_frame(last_of_frame), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// bit-serial integer square root, floor
	function automatic int unsigned int_sqrt(input int unsigned x);
		int unsigned res, one;
		res = 0;
		one = 32'h4000_0000;
		while (one > x) one = one >> 2;
		while (one != 0) begin
			if (x >= res + one) begin
				x = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg < 3) return 3;
		if (width_reg > MaxW) return MaxW;
		return {21'd0, width_reg};
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 3) ? 3 : {16'd0, height_reg};
	endfunction

	function automatic void restart_frame();
		next_col = 0;
		next_row = 0;
		foreach (win[i]) win[i] = '0;
	endfunction

	function automatic void apply_cfg(input reg_idx_t idx, input logic [CfgW-1:0] data);
		if (idx == REG_WIDTH) width_reg = data[10:0];
		else height_reg = data;
		restart_frame();
	endfunction

	// advance the window by one pixel; returns 1 when an interior result is due
	function automatic bit sobel_step(input logic [7:0] pix, output grad_res_t r);
		int unsigned w, h, c, rr, sq;
		int top, mid, bot, hs, vs;
		bit has;
		w = eff_width();
		h = eff_height();
		c = (next_col >= w) ? 0 : next_col;
		rr = (next_row >= h) ? 0 : next_row;
		bot = int'(pix);
		top = int'(row_two_above[c % MaxW]);
		mid = int'(row_above[c % MaxW]);
		has = (rr >= 2 && c >= 2);
		r = '{default: '0};
		if (has) begin
			hs = (win[0] + 2 * win[1] + win[2]) - (top + 2 * mid + bot);
			vs = (win[0] + 2 * win[3] + top) - (win[2] + 2 * win[5] + bot);
			sq = hs * hs + vs * vs;
			r.gh = hs[GradW-1:0];
			r.gv = vs[GradW-1:0];
			r.mag = MagW'(int_sqrt(sq * 256));
			r.row = RowW'(rr - 1);
			r.col = ColOutW'(c - 1);
			r.last = (rr == h - 1 && c == w - 1);
		end
		row_two_above[c % MaxW] = 8'(mid);
		row_above[c % MaxW] = 8'(bot);
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = 8'(top);
		win[4] = 8'(mid);
		win[5] = 8'(bot);
		c++;
		if (c >= w) begin
			c = 0;
			rr++;
			if (rr >= h) rr = 0;
		end
		next_col = c;
		next_row = rr;
		return has;
	endfunction

	// offer one pixel, with random gaps, until the block takes it
	task automatic send_pixel(input logic [7:0] p, input bit typed, input grad_res_t tres);
		grad_res_t r;
		bit has;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		has = sobel_step(p, r);
		if (typed) pending_grads.insert(pending_grads.size(), tres);
		else if (has) pending_grads.insert(pending_grads.size(), r);
	endtask

	// wait for the block to go idle; no more pushes this step
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_grads.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CfgW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_cfg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mixed pixel content: noise, extremes and flat areas
	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(255)) & 8'hF0;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// receiver: checks each transfer, pops with random gaps or a long hold-off
	always @(posedge clk) begin
		grad_res_t e;
		if (pop && !empty) begin
			if (pending_grads.size() == 0) begin
				$display("%0t: unexpected result h=%0d v=%0d mag=%0d row=%0d col=%0d",
					$time, grad_horizontal, grad_vertical, magnitude, center_row, center_col);
				err_count++;
			end else begin
				e = pending_grads.pop_front();
				if (grad_horizontal !== e.gh || grad_vertical !== e.gv || magnitude !== e.mag
						|| center_row !== e.row || center_col !== e.col
						|| last_of_frame !== e.last) begin
					$display("%0t: mismatch exp h=%0d v=%0d mag=%0d row=%0d col=%0d last=%0d",
						$time, $signed(e.gh), $signed(e.gv), e.mag, e.row, e.col, e.last);
					$display("%0t:          got h=%0d v=%0d mag=%0d row=%0d col=%0d last=%0d",
						$time, grad_horizontal, grad_vertical, magnitude, center_row,
						center_col, last_of_frame);
					err_count++;
				end
			end
		end
		pop <= arst_n && !hold_off_req && ($urandom_range(99) >= recv_idle_pct);
	end

	// long hold-off, counted here, so the block backs up and raises full
	initial begin
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				for (n = 0; n < 400; n++) @(posedge clk);
				hold_off_req = 1'b0;
			end
		end
	end

	// random frames: width, height, pixels offered
	int unsigned plan_w [8] = '{5, 0, 2047, 3, 16, 7, 1024, 4};
	int unsigned plan_h [8] = '{4, 0, 3, 65535, 9, 5, 65535, 3};
	int unsigned plan_n [8] = '{200, 60, 400, 300, 300, 230, 60, 50};

	initial begin
		dir_row_t dir [$];
		grad_res_t none;
		int unsigned sent;
		none = '{default: '0};
		foreach (row_above[i]) begin
			row_above[i] = '0;
			row_two_above[i] = '0;
		end
		width_reg = WidthReset;
		height_reg = HeightReset;
		restart_frame();

		// 3x3 frames, one result each at the centre; upper width bits must be dropped
		dir.insert(dir.size(), '{1, REG_WIDTH, 16'hF803, 0, 0, none});
		dir.insert(dir.size(), '{1, REG_HEIGHT, 16'd3, 0, 0, none});
		// left column bright: pure horizontal edge
		for (int k = 0; k < 9; k++)
			dir.insert(dir.size(), '{0, REG_WIDTH, 0, (k % 3 == 0) ? 8'hFF : 8'h00, k == 8,
				'{11'd1020, 11'd0, 15'd16320, 16'd1, 10'd1, 1'b1}});
		// top row bright: pure vertical edge
		for (int k = 0; k < 9; k++)
			dir.insert(dir.size(), '{0, REG_WIDTH, 0, (k < 3) ? 8'hFF : 8'h00, k == 8,
				'{11'd0, 11'd1020, 15'd16320, 16'd1, 10'd1, 1'b1}});
		// flat white: no gradient
		for (int k = 0; k < 9; k++)
			dir.insert(dir.size(), '{0, REG_WIDTH, 0, 8'hFF, k == 8,
				'{11'd0, 11'd0, 15'd0, 16'd1, 10'd1, 1'b1}});

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			if (dir[i].is_cfg) begin
				wait_idle();
				write_reg(dir[i].idx, dir[i].data);
			end else begin
				send_pixel(dir[i].pix, dir[i].typed, dir[i].res);
			end
		end

		sent = 0;
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_reg(REG_WIDTH, CfgW'(plan_w[ph] | ($urandom_range(31) << 11)));
			write_reg(REG_HEIGHT, CfgW'(plan_h[ph]));
			if (ph == 4) hold_off_req = 1'b1;
			for (int k = 0; k < plan_n[ph]; k++) begin
				// receiver-idle mix, then sender-idle mix, then full speed
				if (sent < 530) begin
					send_idle_pct = 31;
					recv_idle_pct = 86;
				end else if (sent < 1070) begin
					send_idle_pct = 86;
					recv_idle_pct = 31;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				send_pixel(pick_pixel(), 1'b0, none);
				sent++;
			end
		end

		wait_idle();
		if (pending_grads.size() != 0) err_count++;
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
